// ===== design/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  localparam int ExpBits = 63;
  localparam int ExpCntW = $clog2(ExpBits + 1);
  localparam logic [30:0] ModulusReset = 31'd1000000007;

  localparam logic [0:0] RegModulus = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ACC,
    ST_RED_ACC,
    ST_MUL_RUN,
    ST_RED_RUN,
    ST_DONE
  } state_t;

  // Handshake between the sequencer and the shared multiply/reduce unit.
  typedef struct packed {
    logic mul_go;
    logic red_go;
  } unit_req_t;

endpackage

// ===== design/mexp_unit.sv =====
// Shared 64-bit multiplier (three 32x32 partial products) and bit-serial reducer.
module mexp_unit (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::unit_req_t req,
  input  logic [63:0]         op_a,
  input  logic [63:0]         op_b,
  input  logic [30:0]         modulus,
  output logic [63:0]         res,
  output logic                done
);

  logic [1:0]  pp_idx;
  logic [63:0] prod;
  logic        mul_busy;
  logic [6:0]  red_cnt;
  logic        red_busy;
  logic [63:0] red_val;
  logic [31:0] rem;
  logic [63:0] pp;
  logic [31:0] pa;
  logic [31:0] pb;
  logic [32:0] rem_sh;

  always_comb begin
    pa = pp_idx[0] ? op_a[63:32] : op_a[31:0];
    pb = pp_idx[1] ? op_b[63:32] : op_b[31:0];
    pp = pa * pb;
    rem_sh = {rem, red_val[63]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      red_busy <= 1'b0;
      done <= 1'b0;
      pp_idx <= 2'd0;
      red_cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.mul_go) begin
        mul_busy <= 1'b1;
        pp_idx <= 2'd0;
        prod <= 64'd0;
      end else if (mul_busy) begin
        unique case (pp_idx)
          2'd0: prod <= prod + pp;
          2'd1, 2'd2: prod <= prod + {pp[31:0], 32'd0};
          default: prod <= prod;
        endcase
        pp_idx <= pp_idx + 2'd1;
        if (pp_idx == 2'd3) begin
          mul_busy <= 1'b0;
          res <= prod;
          done <= 1'b1;
        end
      end
      if (req.red_go) begin
        if (modulus == 31'd0) begin
          done <= 1'b1;
        end else begin
          red_busy <= 1'b1;
          red_cnt <= 7'd0;
          red_val <= res;
          rem <= 32'd0;
        end
      end else if (red_busy) begin
        red_val <= {red_val[62:0], 1'b0};
        if (rem_sh >= {2'b00, modulus}) begin
          rem <= 32'(rem_sh - {2'b00, modulus});
        end else begin
          rem <= rem_sh[31:0];
        end
        red_cnt <= red_cnt + 7'd1;
        if (red_cnt == 7'd63) begin
          red_busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (red_busy && !req.red_go && red_cnt == 7'd63) begin
        res <= {32'd0, (rem_sh >= {2'b00, modulus}) ?
                32'(rem_sh - {2'b00, modulus}) : rem_sh[31:0]};
      end
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst) !(mul_busy && red_busy))
    else $error("multiplier and reducer active together");
  a_go: assert property (@(posedge clk) disable iff (rst)
    !(req.mul_go && req.red_go)) else $error("two unit requests at once");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    red_busy |-> rem < {1'b0, modulus}) else $error("remainder out of range");

endmodule

// ===== design/modular_exponentiation_top.sv =====
// Top level of the square-and-multiply modular exponentiation block.
// Per scanned exponent bit, the shared multiply/reduce unit does up to two multiplies
// and two reductions (a reduction is skipped when modulus is 0); at most 63 bits
// are scanned.
// Throughput: one item at a time; busy is high from acceptance until the result beat.
// Reset: rst is synchronous; the sequencer idles and modulus returns to 1000000007.
module modular_exponentiation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] base,
  input  logic [62:0] exponent,
  output logic        strobe,
  output logic signed [63:0] power,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mexp_pkg::state_t state, state_next;
  mexp_pkg::unit_req_t req;
  logic [30:0] modulus;
  logic [63:0] acc;
  logic [63:0] run;
  logic [62:0] e;
  logic [mexp_pkg::ExpCntW-1:0] bit_cnt;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] ures;
  logic        udone;

  // Configuration: the modulus is the only register, at paddr 0.
  assign pready = 1'b1;
  assign prdata = {1'b0, modulus};
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::ModulusReset;
    end else if (psel && penable && pwrite && paddr == mexp_pkg::RegModulus) begin
      modulus <= pwdata[30:0];
    end
  end

  assign busy = (state != mexp_pkg::ST_IDLE);
  assign op_a = (state == mexp_pkg::ST_MUL_ACC) ? acc : run;
  assign op_b = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Data registers are loaded when a start is accepted and updated as each reduction finishes.
  always_ff @(posedge clk) begin
    if (state == mexp_pkg::ST_IDLE && start) begin
      acc <= 64'd1;
      run <= {33'd0, base};
      e <= exponent;
      bit_cnt <= '0;
    end else if (udone) begin
      if (state == mexp_pkg::ST_RED_ACC) acc <= ures;
      if (state == mexp_pkg::ST_RED_RUN) begin
        run <= ures;
        e <= e >> 1;
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    req = '0;
    strobe = 1'b0;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (start) state_next = mexp_pkg::ST_DONE;
        if (start && exponent != 63'd0) begin
          state_next = exponent[0] ? mexp_pkg::ST_MUL_ACC : mexp_pkg::ST_MUL_RUN;
          req.mul_go = 1'b1;
        end
      end
      mexp_pkg::ST_MUL_ACC: if (udone) begin
        state_next = mexp_pkg::ST_RED_ACC;
        req.red_go = 1'b1;
      end
      mexp_pkg::ST_RED_ACC: if (udone) begin
        state_next = mexp_pkg::ST_MUL_RUN;
        req.mul_go = 1'b1;
      end
      mexp_pkg::ST_MUL_RUN: if (udone) begin
        state_next = mexp_pkg::ST_RED_RUN;
        req.red_go = 1'b1;
      end
      mexp_pkg::ST_RED_RUN: if (udone) begin
        if (e[62:1] == 62'd0 ||
            bit_cnt == mexp_pkg::ExpCntW'(mexp_pkg::ExpBits - 1)) begin
          state_next = mexp_pkg::ST_DONE;
        end else begin
          state_next = e[1] ? mexp_pkg::ST_MUL_ACC : mexp_pkg::ST_MUL_RUN;
          req.mul_go = 1'b1;
        end
      end
      mexp_pkg::ST_DONE: begin
        strobe = 1'b1;
        state_next = mexp_pkg::ST_IDLE;
      end
      default: state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  assign power = acc;

  mexp_unit u_unit (
    .clk(clk), .rst(rst), .req(req), .op_a(op_a), .op_b(op_b),
    .modulus(modulus), .res(ures), .done(udone)
  );

  a_strobe: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("result beat lasted two cycles");
  a_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result beat while idle");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the square-and-multiply modular exponentiation block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One command beat: the value to raise and the power to raise it to.
  typedef struct {
    logic [30:0] base;
    logic [62:0] exponent;
  } power_cmd_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [30:0] base;
  logic [62:0] exponent;
  logic        strobe;
  logic signed [63:0] power;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  modular_exponentiation_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .base(base), .exponent(exponent), .strobe(strobe), .power(power),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Commands waiting to be driven, and powers that the block still owes us.
  power_cmd_t      pending_cmds[$];
  logic [63:0]     owed_powers[$];

  // Our own copy of the modulus register, updated as it is written.
  logic [30:0] modulus_copy;

  int unsigned gap_left;
  int unsigned n_mismatch;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_config;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Right-to-left square and multiply. The first base is used unreduced, and
  // the initial result of 1 is never reduced, so exponent 0 always gives 1.
  function automatic logic [63:0] square_multiply(logic [30:0] b, logic [62:0] e,
                                                  logic [30:0] m);
    longint unsigned run;
    longint unsigned acc;
    longint unsigned bits;
    longint unsigned md;
    run  = {33'd0, b};
    acc  = 64'd1;
    bits = {1'b0, e};
    md   = {33'd0, m};
    for (int i = 0; i < mexp_pkg::ExpBits; i++) begin
      if (bits == 0) break;
      if (bits[0]) begin
        acc = acc * run;
        if (md != 0) acc = acc % md;
      end
      run = run * run;
      if (md != 0) run = run % md;
      bits = bits >> 1;
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_mismatch++;
    $display("MISMATCH %s: got %0d (0x%h), expected %0d (0x%h) at %0t",
             what, $signed(got), got, $signed(want), want, $realtime);
  endtask

  // Random idle length before the next command: mostly none, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver. A beat is taken at an edge where start is high and busy low; the
  // expected power is computed right there with the current modulus. The next
  // value of start is settled in a variable so it is assigned once per edge.
  always @(posedge clk) begin
    logic       drive_next;
    power_cmd_t cmd;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      drive_next = start;
      if (start && !busy) begin
        owed_powers.push_back(square_multiply(base, exponent, modulus_copy));
        n_accepted++;
        drive_next = 1'b0;
      end
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd        = pending_cmds.pop_front();
          base      <= cmd.base;
          exponent  <= cmd.exponent;
          drive_next = 1'b1;
          gap_left  <= pick_gap();
        end
      end
      start <= drive_next;
    end
  end

  // Monitor. A result beat lasts one cycle and cannot be held off, so it is
  // checked at the edge that ends it against the oldest owed power.
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && strobe) begin
      if (owed_powers.size() == 0) begin
        report_mismatch("unexpected result beat", power, 64'd0);
      end else begin
        want = owed_powers.pop_front();
        n_checked++;
        if (power !== want) report_mismatch("power", power, want);
      end
    end
  end

  // Register write over the APB port: a setup cycle, then an access cycle.
  // Only the modulus register exists; the copy mirrors the masking of bit 31
  // and ignores writes to any other address.
  task automatic write_reg(logic [0:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == mexp_pkg::RegModulus) modulus_copy = data[30:0];
    n_config++;
  endtask

  // Waits until every queued command has been taken and every power checked,
  // then lets the block settle before the next register write.
  task automatic drain();
    while (pending_cmds.size() > 0 || owed_powers.size() > 0 || start || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_cmd(logic [30:0] b, logic [62:0] e);
    power_cmd_t cmd;
    cmd.base     = b;
    cmd.exponent = e;
    pending_cmds.push_back(cmd);
  endtask

  // Random exponent: most are short so the run stays fast, some use all bits.
  function automatic logic [62:0] rand_exponent();
    logic [63:0] raw;
    int unsigned len;
    int unsigned r;
    raw = {$urandom, $urandom};
    r   = $urandom_range(0, 99);
    if (r < 15) len = 63;
    else if (r < 30) len = $urandom_range(17, 62);
    else len = $urandom_range(0, 16);
    if (len == 0) return 63'd0;
    return raw[62:0] & ((63'd1 << len) - 63'd1) | (len == 63 ? raw[62:0] : 63'd0);
  endfunction

  function automatic logic [30:0] rand_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 31'($urandom_range(0, 3));
    if (r < 4) return 31'h7fffffff - 31'($urandom_range(0, 3));
    return 31'($urandom);
  endfunction

  task automatic random_cmds(int unsigned n);
    repeat (n) queue_cmd(rand_base(), rand_exponent());
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    base         = '0;
    exponent     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    modulus_copy = mexp_pkg::ModulusReset;
    n_mismatch   = 0;
    n_accepted   = 0;
    n_checked    = 0;
    n_config     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset modulus: zero exponent, zero base, full-width fields.
    queue_cmd(31'd0, 63'd0);
    queue_cmd(31'd0, 63'd1);
    queue_cmd(31'd7, 63'd0);
    queue_cmd(31'h7fffffff, 63'd1);
    queue_cmd(31'h7fffffff, {63{1'b1}});
    queue_cmd(31'd2, 63'd61);
    drain();

    // Modulus 1: exponent 0 still yields 1, everything else 0.
    write_reg(mexp_pkg::RegModulus, 32'd1);
    queue_cmd(31'd5, 63'd0);
    queue_cmd(31'd5, 63'd9);
    queue_cmd(31'h7fffffff, {63{1'b1}});
    drain();

    // Modulus 0 turns reduction off, so products wrap at 64 bits.
    write_reg(mexp_pkg::RegModulus, 32'd0);
    queue_cmd(31'd3, 63'd100);
    queue_cmd(31'd2, 63'd63);
    queue_cmd(31'd2, 63'd64);
    queue_cmd(31'h7fffffff, {63{1'b1}});
    queue_cmd(31'h55555555, 63'h2aaaaaaaaaaaaaaa);
    drain();

    // Bit 31 of the write data is dropped, giving the largest modulus.
    write_reg(mexp_pkg::RegModulus, 32'hffffffff);
    queue_cmd(31'h7ffffffe, {63{1'b1}});
    queue_cmd(31'h7fffffff, 63'd3);
    queue_cmd(31'h2aaaaaaa, 63'h5555555555555555);
    drain();

    // A write to the unused address must leave modulus alone.
    write_reg(mexp_pkg::RegModulus, 32'd2);
    write_reg(~mexp_pkg::RegModulus, 32'd97);
    queue_cmd(31'd3, 63'd5);
    queue_cmd(31'h7fffffff, {63{1'b1}});
    drain();

    // Random phases across several moduli, extremes included.
    write_reg(mexp_pkg::RegModulus, {1'b1, 31'($urandom)});
    random_cmds(25);
    drain();
    write_reg(mexp_pkg::RegModulus, 32'($urandom_range(2, 1000)));
    random_cmds(25);
    drain();
    write_reg(mexp_pkg::RegModulus, 32'd0);
    random_cmds(25);
    drain();
    write_reg(mexp_pkg::RegModulus, 32'h7fffffff);
    random_cmds(25);
    drain();

    $display("Covered %0d command beats and %0d checked results over %0d register writes.",
             n_accepted, n_checked, n_config);
    $display("Moduli included reset, 0, 1, 2, the largest, a random small and a random wide one.");
    if (n_mismatch == 0 && owed_powers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout guard, sized for the worst case over every queued command.
  initial begin
    #60ms;
    $display("Timeout with %0d results still owed.", owed_powers.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== modular_exponentiation_top.f =====
design/mexp_pkg.sv
design/mexp_unit.sv
design/modular_exponentiation_top.sv
test/testbench.sv
